[rtl/core/tlpa_pkg.sv]
// tlpa_pkg: constants, register and layout codes and helper functions for the
// tensor layout permute address generator
// no dependencies
package tlpa_pkg;

    // sizes
    localparam int ADDR_BITS = 24;
    localparam int DIM_BITS  = 12;
    localparam int NUM_DIMS  = 4;
    localparam int REG_W     = 13;
    localparam int MODE_W    = 3;
    localparam int ELEM_W    = 32;
    localparam int DEST_W    = 24;
    localparam int CFG_IDX_W = 3;
    localparam int EFF_W     = DIM_BITS + 1;
    localparam int PROD_W    = NUM_DIMS * EFF_W;
    localparam int SEQ_W     = $clog2(2 * NUM_DIMS);
    localparam int SEQ_LAST  = 2 * NUM_DIMS - 1;
    localparam int CMP_W     = (REG_W > EFF_W) ? REG_W : EFF_W;

    typedef logic [MODE_W-1:0]    mode_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
    typedef logic [1:0]           dim_sel_t;

    // layout modes
    localparam mode_t MODE_TO_HWNC      = 3'd0;
    localparam mode_t MODE_TO_HWCN      = 3'd1;
    localparam mode_t MODE_TO_NHWC      = 3'd2;
    localparam mode_t MODE_TO_CHWN      = 3'd3;
    localparam mode_t MODE_NHWC_TO_NCHW = 3'd4;

    // register indexes
    localparam cfg_idx_t REG_LAYOUT_MODE   = 3'd0;
    localparam cfg_idx_t REG_BATCH_COUNT   = 3'd1;
    localparam cfg_idx_t REG_CHANNEL_COUNT = 3'd2;
    localparam cfg_idx_t REG_ROW_COUNT     = 3'd3;
    localparam cfg_idx_t REG_COLUMN_COUNT  = 3'd4;

    // dimension slots
    localparam dim_sel_t DIM_N = 2'd0;
    localparam dim_sel_t DIM_C = 2'd1;
    localparam dim_sel_t DIM_H = 2'd2;
    localparam dim_sel_t DIM_W = 2'd3;

    // dimension at a given rank of the destination layout, innermost first
    function automatic dim_sel_t dim_order(input mode_t mode, input logic [1:0] rank);
        dim_sel_t d;
        case (mode)
            MODE_TO_HWCN:
            begin
                case (rank)
                    2'd0:    d = DIM_N;
                    2'd1:    d = DIM_C;
                    2'd2:    d = DIM_W;
                    default: d = DIM_H;
                endcase
            end
            MODE_TO_NHWC:
            begin
                case (rank)
                    2'd0:    d = DIM_C;
                    2'd1:    d = DIM_W;
                    2'd2:    d = DIM_H;
                    default: d = DIM_N;
                endcase
            end
            MODE_NHWC_TO_NCHW:
            begin
                case (rank)
                    2'd0:    d = DIM_W;
                    2'd1:    d = DIM_H;
                    2'd2:    d = DIM_C;
                    default: d = DIM_N;
                endcase
            end
            MODE_TO_CHWN:
            begin
                case (rank)
                    2'd0:    d = DIM_N;
                    2'd1:    d = DIM_W;
                    2'd2:    d = DIM_H;
                    default: d = DIM_C;
                endcase
            end
            default:
            begin
                case (rank)
                    2'd0:    d = DIM_C;
                    2'd1:    d = DIM_N;
                    2'd2:    d = DIM_W;
                    default: d = DIM_H;
                endcase
            end
        endcase
        return d;
    endfunction

    // zero counts as one, counts above the index range saturate
    function automatic logic [EFF_W-1:0] eff_dim(input logic [REG_W-1:0] count);
        logic [CMP_W-1:0] v;
        logic [CMP_W-1:0] cap;
        v   = CMP_W'(count);
        cap = CMP_W'(1) << DIM_BITS;
        if (v == '0)
        begin
            v = CMP_W'(1);
        end
        else if (v > cap)
        begin
            v = cap;
        end
        return EFF_W'(v);
    endfunction

endpackage

[rtl/core/tlpa_if.sv]
// tlpa channel interfaces: element input, result output and register write
// depends on tlpa_pkg
interface tlpa_elem_if;
    logic                        valid;
    logic                        ready;
    logic [tlpa_pkg::ELEM_W-1:0] element_bits;

    modport source (output valid, output element_bits, input ready);
    modport sink (input valid, input element_bits, output ready);
endinterface

interface tlpa_result_if;
    logic                        valid;
    logic                        ready;
    logic [tlpa_pkg::ELEM_W-1:0] element_out;
    logic [tlpa_pkg::DEST_W-1:0] dest_address;
    logic                        last_element;
    logic                        size_overflow;

    modport source (output valid, output element_out, output dest_address,
                    output last_element, output size_overflow, input ready);
    modport sink (input valid, input element_out, input dest_address,
                  input last_element, input size_overflow, output ready);
endinterface

interface tlpa_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [tlpa_pkg::CFG_IDX_W-1:0] reg_index;
    logic [tlpa_pkg::REG_W-1:0]     reg_data;

    modport source (output valid, output reg_index, output reg_data, input ready);
    modport sink (input valid, input reg_index, input reg_data, output ready);
endinterface

[rtl/core/tensor_layout_permute_address.sv]
// tensor_layout_permute_address: top level, counters, address and register file
// depends on tlpa_pkg and the tlpa channel interfaces
//
// Streams 32-bit elements through and tags each with its index in the target
// layout. While not busy and not stalled, one element is taken per clock cycle and
// its result is held in the output register in the next cycle; a new request
// is taken in the same cycle as the previous result leaves, so a stalled result
// holds the input. The address is the sum of four partial addresses (index
// times stride), each kept up to date by an add when its counter steps, so the
// per-element path is a few adds. After any register write the block holds input
// ready low while it builds the strides and the tensor size through one multiplier
// chain, innermost dimension first, then rebuilds the partial addresses from the
// current counters. Register writes are always accepted and restart that sequence.
module tensor_layout_permute_address
(
    input  logic             clk,
    input  logic             rst_n,
    tlpa_elem_if.sink        elements,
    tlpa_result_if.source    results,
    tlpa_cfg_if.sink         cfg
);

    localparam int AW   = tlpa_pkg::ADDR_BITS;
    localparam int DW   = tlpa_pkg::DIM_BITS;
    localparam int ND   = tlpa_pkg::NUM_DIMS;
    localparam int EW   = tlpa_pkg::EFF_W;
    localparam int PW   = tlpa_pkg::PROD_W;
    localparam int SPW  = (PW > AW) ? PW : AW;
    localparam int OCW  = (PW > AW + 1) ? PW : AW + 1;
    localparam int DXW  = (AW > tlpa_pkg::DEST_W) ? AW : tlpa_pkg::DEST_W;

    // registers
    tlpa_pkg::mode_t                mode_reg;
    logic [tlpa_pkg::REG_W-1:0]     count_reg [ND];
    logic [DW-1:0]                  idx_reg [ND];
    logic [DW-1:0]                  idx_next [ND];
    logic [AW-1:0]                  part_reg [ND];
    logic [AW-1:0]                  part_next [ND];
    logic [AW-1:0]                  stride_reg [ND];
    logic [AW-1:0]                  stride_next [ND];
    logic [PW-1:0]                  prod_reg;
    logic [PW-1:0]                  prod_next;
    logic                           overflow_reg;
    logic                           overflow_next;
    logic                           busy_reg;
    logic                           busy_next;
    logic [tlpa_pkg::SEQ_W-1:0]     step_reg;
    logic [tlpa_pkg::SEQ_W-1:0]     step_next;

    logic                           res_valid_reg;
    logic [tlpa_pkg::ELEM_W-1:0]    res_elem_reg;
    logic [tlpa_pkg::DEST_W-1:0]    res_addr_reg;
    logic                           res_last_reg;
    logic                           res_ovf_reg;

    // combinational
    logic [EW-1:0]                  eff [ND];
    logic [ND-1:0]                  at_last;
    logic [ND-1:0]                  inc;
    logic                           in_ready;
    logic                           in_fire;
    logic                           cfg_fire;
    logic [AW-1:0]                  addr_sum;
    logic [DXW-1:0]                 addr_ext;
    logic [1:0]                     seq_rank;
    tlpa_pkg::dim_sel_t             seq_dim;
    logic [EW-1:0]                  seq_eff;
    logic [PW+EW-1:0]               prod_mul;
    logic [SPW-1:0]                 prod_ext;
    logic [OCW-1:0]                 prod_cmp;
    logic [DW+AW-1:0]               part_mul;

    // handshakes
    assign cfg.ready      = 1'b1;
    assign cfg_fire       = cfg.valid;
    assign in_ready       = !busy_reg && !cfg.valid && (!res_valid_reg || results.ready);
    assign elements.ready = in_ready;
    assign in_fire        = elements.valid && in_ready;

    // effective dimensions and last flags
    always_comb
    begin
        for (int d = 0; d < ND; d++)
        begin
            eff[d]     = tlpa_pkg::eff_dim(count_reg[d]);
            at_last[d] = ((EW'(idx_reg[d]) + EW'(1)) >= eff[d]);
        end
    end

    // source loop order decides which counters step
    always_comb
    begin
        inc = '0;
        if (mode_reg == tlpa_pkg::MODE_NHWC_TO_NCHW)
        begin
            inc[tlpa_pkg::DIM_C] = 1'b1;
            inc[tlpa_pkg::DIM_W] = at_last[tlpa_pkg::DIM_C];
            inc[tlpa_pkg::DIM_H] = at_last[tlpa_pkg::DIM_C] && at_last[tlpa_pkg::DIM_W];
            inc[tlpa_pkg::DIM_N] = at_last[tlpa_pkg::DIM_C] && at_last[tlpa_pkg::DIM_W]
                                   && at_last[tlpa_pkg::DIM_H];
        end
        else
        begin
            inc[tlpa_pkg::DIM_W] = 1'b1;
            inc[tlpa_pkg::DIM_H] = at_last[tlpa_pkg::DIM_W];
            inc[tlpa_pkg::DIM_C] = at_last[tlpa_pkg::DIM_W] && at_last[tlpa_pkg::DIM_H];
            inc[tlpa_pkg::DIM_N] = at_last[tlpa_pkg::DIM_W] && at_last[tlpa_pkg::DIM_H]
                                   && at_last[tlpa_pkg::DIM_C];
        end
    end

    // destination address from partial addresses
    always_comb
    begin
        addr_sum = part_reg[0] + part_reg[1] + part_reg[2] + part_reg[3];
        addr_ext = DXW'(addr_sum);
    end

    // stride and partial address sequencer datapath
    always_comb
    begin
        seq_rank = step_reg[1:0];
        seq_dim  = tlpa_pkg::dim_order(mode_reg, seq_rank);
        seq_eff  = eff[seq_dim];
        prod_mul = prod_reg * seq_eff;
        prod_ext = SPW'(prod_reg);
        prod_cmp = OCW'(prod_reg);
        part_mul = idx_reg[seq_rank] * stride_reg[seq_rank];
    end

    // next state for counters, partial addresses and sequencer
    always_comb
    begin
        idx_next      = idx_reg;
        part_next     = part_reg;
        stride_next   = stride_reg;
        prod_next     = prod_reg;
        overflow_next = overflow_reg;
        busy_next     = busy_reg;
        step_next     = step_reg;

        if (in_fire)
        begin
            for (int d = 0; d < ND; d++)
            begin
                if (inc[d])
                begin
                    if (at_last[d])
                    begin
                        idx_next[d]  = '0;
                        part_next[d] = '0;
                    end
                    else
                    begin
                        idx_next[d]  = idx_reg[d] + DW'(1);
                        part_next[d] = part_reg[d] + stride_reg[d];
                    end
                end
            end
        end

        if (cfg_fire)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            if (!step_reg[tlpa_pkg::SEQ_W-1])
            begin
                // strides, innermost dimension first
                if (seq_rank == 2'd0)
                begin
                    stride_next[seq_dim] = AW'(1);
                    prod_next            = PW'(seq_eff);
                end
                else
                begin
                    stride_next[seq_dim] = prod_ext[AW-1:0];
                    prod_next            = prod_mul[PW-1:0];
                end
            end
            else
            begin
                // partial addresses from the current counters
                part_next[seq_rank] = part_mul[AW-1:0];
                if (seq_rank == 2'd0)
                begin
                    overflow_next = (prod_cmp > (OCW'(1) << AW));
                end
            end
            step_next = step_reg + tlpa_pkg::SEQ_W'(1);
            if (step_reg == tlpa_pkg::SEQ_W'(tlpa_pkg::SEQ_LAST))
            begin
                busy_next = 1'b0;
            end
        end
    end

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tlpa_pkg::MODE_TO_HWNC;
            for (int d = 0; d < ND; d++)
            begin
                count_reg[d] <= tlpa_pkg::REG_W'(1);
            end
        end
        else if (cfg_fire)
        begin
            case (cfg.reg_index)
                tlpa_pkg::REG_LAYOUT_MODE:   mode_reg <= cfg.reg_data[tlpa_pkg::MODE_W-1:0];
                tlpa_pkg::REG_BATCH_COUNT:   count_reg[tlpa_pkg::DIM_N] <= cfg.reg_data;
                tlpa_pkg::REG_CHANNEL_COUNT: count_reg[tlpa_pkg::DIM_C] <= cfg.reg_data;
                tlpa_pkg::REG_ROW_COUNT:     count_reg[tlpa_pkg::DIM_H] <= cfg.reg_data;
                tlpa_pkg::REG_COLUMN_COUNT:  count_reg[tlpa_pkg::DIM_W] <= cfg.reg_data;
                default:                     ;
            endcase
        end
    end

    // counters, strides and sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < ND; d++)
            begin
                idx_reg[d]    <= '0;
                part_reg[d]   <= '0;
                stride_reg[d] <= AW'(1);
            end
            prod_reg     <= PW'(1);
            overflow_reg <= 1'b0;
            busy_reg     <= 1'b0;
            step_reg     <= '0;
        end
        else
        begin
            idx_reg      <= idx_next;
            part_reg     <= part_next;
            stride_reg   <= stride_next;
            prod_reg     <= prod_next;
            overflow_reg <= overflow_next;
            busy_reg     <= busy_next;
            step_reg     <= step_next;
        end
    end

    // result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            res_elem_reg <= elements.element_bits;
            res_addr_reg <= addr_ext[tlpa_pkg::DEST_W-1:0];
            res_last_reg <= &at_last;
            res_ovf_reg  <= overflow_reg;
        end
    end

    assign results.valid         = res_valid_reg;
    assign results.element_out   = res_elem_reg;
    assign results.dest_address  = res_addr_reg;
    assign results.last_element  = res_last_reg;
    assign results.size_overflow = res_ovf_reg;

endmodule

[dv/tensor_layout_permute_address_tb.sv]
// testbench for tensor_layout_permute_address: streams elements through every layout
// mode and random dimension settings and checks each result against a local model
// depends on tlpa_pkg, the tlpa channel interfaces and the block itself
module tensor_layout_permute_address_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // highest layout code; the unused codes fold onto the first layout
    localparam tlpa_pkg::mode_t MODE_UNUSED_HI = 3'd7;

    // register indexes with no register behind them
    localparam tlpa_pkg::cfg_idx_t REG_SPARE_LO = 3'd5;
    localparam tlpa_pkg::cfg_idx_t REG_SPARE_HI = 3'd7;

    localparam int ELEMENT_TARGET = 700;
    localparam int REPORT_LIMIT   = 10;

    typedef struct {
        logic [tlpa_pkg::ELEM_W-1:0] element;
        logic [tlpa_pkg::DEST_W-1:0] address;
        logic                        last;
        logic                        overflow;
    } permuted_elem_t;

    logic clk = 1'b0;
    logic rst_n;

    tlpa_elem_if   elem_ch ();
    tlpa_result_if result_ch ();
    tlpa_cfg_if    cfg_ch ();

    tensor_layout_permute_address DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .elements (elem_ch),
        .results  (result_ch),
        .cfg      (cfg_ch)
    );

    // shadow of the register file
    tlpa_pkg::mode_t            layout_sh = tlpa_pkg::MODE_TO_HWNC;
    logic [tlpa_pkg::REG_W-1:0] batch_sh  = tlpa_pkg::REG_W'(1);
    logic [tlpa_pkg::REG_W-1:0] chan_sh   = tlpa_pkg::REG_W'(1);
    logic [tlpa_pkg::REG_W-1:0] row_sh    = tlpa_pkg::REG_W'(1);
    logic [tlpa_pkg::REG_W-1:0] col_sh    = tlpa_pkg::REG_W'(1);

    // shadow of the source-order position
    logic [tlpa_pkg::DIM_BITS-1:0] pos_n = '0;
    logic [tlpa_pkg::DIM_BITS-1:0] pos_c = '0;
    logic [tlpa_pkg::DIM_BITS-1:0] pos_h = '0;
    logic [tlpa_pkg::DIM_BITS-1:0] pos_w = '0;

    permuted_elem_t pending_results[$];

    bit quiet = 1'b0;
    int elements_sent   = 0;
    int results_checked = 0;
    int tensors_closed  = 0;
    int overflow_seen   = 0;
    int cfg_writes      = 0;
    int error_count     = 0;

    logic result_ready = 1'b0;
    int   stall_left   = 0;

    assign result_ch.ready = result_ready;

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
        begin
            return 0;
        end
        if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    // zero counts as one, anything past the index range saturates
    function automatic longint unsigned eff_count(input logic [tlpa_pkg::REG_W-1:0] count);
        longint unsigned v;
        longint unsigned cap;
        v   = 64'(count);
        cap = 64'd1 << tlpa_pkg::DIM_BITS;
        if (v == 0)
        begin
            return 1;
        end
        if (v > cap)
        begin
            return cap;
        end
        return v;
    endfunction

    // next counter value; zero means the counter wrapped
    function automatic logic [tlpa_pkg::DIM_BITS-1:0] step_index(
        input logic [tlpa_pkg::DIM_BITS-1:0] idx,
        input longint unsigned dim);
        longint unsigned v;
        v = 64'(idx);
        if (v + 1 >= dim)
        begin
            return '0;
        end
        return idx + 1'b1;
    endfunction

    // expected result for one element, then advance the source-order counters
    task automatic predict_permutation(input logic [tlpa_pkg::ELEM_W-1:0] bits);
        longint unsigned nd, cd, hd, wd;
        longint unsigned n, c, h, w;
        longint unsigned addr;
        permuted_elem_t  res;
        nd = eff_count(batch_sh);
        cd = eff_count(chan_sh);
        hd = eff_count(row_sh);
        wd = eff_count(col_sh);
        n  = 64'(pos_n);
        c  = 64'(pos_c);
        h  = 64'(pos_h);
        w  = 64'(pos_w);
        case (layout_sh)
            tlpa_pkg::MODE_TO_HWCN:      addr = ((h * wd + w) * cd + c) * nd + n;
            tlpa_pkg::MODE_TO_NHWC:      addr = ((n * hd + h) * wd + w) * cd + c;
            tlpa_pkg::MODE_TO_CHWN:      addr = ((c * hd + h) * wd + w) * nd + n;
            tlpa_pkg::MODE_NHWC_TO_NCHW: addr = ((n * cd + c) * hd + h) * wd + w;
            default:                     addr = ((h * wd + w) * nd + n) * cd + c;
        endcase
        res.element  = bits;
        res.address  = addr[tlpa_pkg::DEST_W-1:0];
        res.last     = (n + 1 >= nd) && (c + 1 >= cd) && (h + 1 >= hd) && (w + 1 >= wd);
        res.overflow = (nd * cd * hd * wd) > (64'd1 << tlpa_pkg::ADDR_BITS);
        pending_results.push_back(res);

        // source loop order: channel fastest for NHWC input, column fastest otherwise
        if (layout_sh == tlpa_pkg::MODE_NHWC_TO_NCHW)
        begin
            pos_c = step_index(pos_c, cd);
            if (pos_c == '0)
            begin
                pos_w = step_index(pos_w, wd);
                if (pos_w == '0)
                begin
                    pos_h = step_index(pos_h, hd);
                    if (pos_h == '0)
                    begin
                        pos_n = step_index(pos_n, nd);
                    end
                end
            end
        end
        else
        begin
            pos_w = step_index(pos_w, wd);
            if (pos_w == '0)
            begin
                pos_h = step_index(pos_h, hd);
                if (pos_h == '0)
                begin
                    pos_c = step_index(pos_c, cd);
                    if (pos_c == '0)
                    begin
                        pos_n = step_index(pos_n, nd);
                    end
                end
            end
        end
    endtask

    // send one element request and record its expected result
    task automatic send_element(input logic [tlpa_pkg::ELEM_W-1:0] bits);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            elem_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        elem_ch.valid        <= 1'b1;
        elem_ch.element_bits <= bits;
        do @(posedge clk); while (!elem_ch.ready);
        predict_permutation(bits);
        elements_sent++;
    endtask

    // register write, only while nothing is in flight
    task automatic write_reg(input tlpa_pkg::cfg_idx_t idx,
                             input logic [tlpa_pkg::REG_W-1:0] data);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            repeat (gap) @(posedge clk);
        end
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        case (idx)
            tlpa_pkg::REG_LAYOUT_MODE:   layout_sh = data[tlpa_pkg::MODE_W-1:0];
            tlpa_pkg::REG_BATCH_COUNT:   batch_sh  = data;
            tlpa_pkg::REG_CHANNEL_COUNT: chan_sh   = data;
            tlpa_pkg::REG_ROW_COUNT:     row_sh    = data;
            tlpa_pkg::REG_COLUMN_COUNT:  col_sh    = data;
            default:                     ;
        endcase
        cfg_writes++;
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_dims(input logic [tlpa_pkg::REG_W-1:0] n,
                              input logic [tlpa_pkg::REG_W-1:0] c,
                              input logic [tlpa_pkg::REG_W-1:0] h,
                              input logic [tlpa_pkg::REG_W-1:0] w);
        write_reg(tlpa_pkg::REG_BATCH_COUNT, n);
        write_reg(tlpa_pkg::REG_CHANNEL_COUNT, c);
        write_reg(tlpa_pkg::REG_ROW_COUNT, h);
        write_reg(tlpa_pkg::REG_COLUMN_COUNT, w);
    endtask

    // stop sending and let every result drain
    task automatic settle();
        elem_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // count value that hits the zero, one and saturation corners
    function automatic logic [tlpa_pkg::REG_W-1:0] pick_edge_count();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return tlpa_pkg::REG_W'(1);
            2:       return tlpa_pkg::REG_W'(1 << tlpa_pkg::DIM_BITS);
            3:       return tlpa_pkg::REG_W'($urandom_range((1 << tlpa_pkg::DIM_BITS) + 1,
                                                            (1 << tlpa_pkg::REG_W) - 1));
            default: return tlpa_pkg::REG_W'($urandom_range(1, (1 << tlpa_pkg::REG_W) - 1));
        endcase
    endfunction

    // result sink with random stalls
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left   <= pick_gap();
        end
    end

    // result checker
    always @(posedge clk)
    begin
        permuted_elem_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_LIMIT)
                begin
                    $display("%0t: result with no request pending: elem %h addr %h",
                             $realtime, result_ch.element_out, result_ch.dest_address);
                end
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (result_ch.last_element)
                begin
                    tensors_closed++;
                end
                if (result_ch.size_overflow)
                begin
                    overflow_seen++;
                end
                if (result_ch.element_out !== want.element ||
                    result_ch.dest_address !== want.address ||
                    result_ch.last_element !== want.last ||
                    result_ch.size_overflow !== want.overflow)
                begin
                    error_count++;
                    if (error_count <= REPORT_LIMIT)
                    begin
                        $display("%0t: mismatch exp elem %h addr %h last %b ovf %b",
                                 $realtime, want.element, want.address, want.last,
                                 want.overflow);
                        $display("%0t:          got elem %h addr %h last %b ovf %b",
                                 $realtime, result_ch.element_out, result_ch.dest_address,
                                 result_ch.last_element, result_ch.size_overflow);
                    end
                end
            end
        end
    end

    // defaults after reset: single-element tensor, extreme data
    task automatic test_reset_defaults();
        send_element('0);
        send_element('1);
    endtask

    // saturated counts with an address that wraps and an oversized tensor
    task automatic test_saturation_and_wrap();
        settle();
        write_reg(tlpa_pkg::REG_LAYOUT_MODE, tlpa_pkg::REG_W'(tlpa_pkg::MODE_TO_HWCN));
        write_dims(13'd4095, 13'd4095, 13'd4097, 13'd2);
        write_reg(tlpa_pkg::REG_CHANNEL_COUNT, '1);
        write_reg(tlpa_pkg::REG_CHANNEL_COUNT, 13'd4095);
        repeat (3) send_element($urandom);
    endtask

    // zero counts act as one; counters left past their new dimension wrap
    task automatic test_zero_and_shrunk_counts();
        settle();
        write_dims('0, '0, '0, '0);
        repeat (2) send_element($urandom);
    endtask

    // each layout code in turn, switched mid-tensor
    task automatic test_each_layout();
        settle();
        write_dims(13'd2, 13'd2, 13'd2, 13'd2);
        for (int m = tlpa_pkg::MODE_TO_HWNC; m <= MODE_UNUSED_HI; m++)
        begin
            settle();
            write_reg(tlpa_pkg::REG_LAYOUT_MODE, tlpa_pkg::REG_W'(m));
            repeat (2) send_element($urandom);
        end
    endtask

    // random phases: mostly whole small tensors, some corner counts and lone writes
    task automatic test_random_streams();
        int kind;
        int volume;
        int count;
        while (elements_sent < ELEMENT_TARGET)
        begin
            settle();
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 70)
            begin
                write_reg(tlpa_pkg::REG_LAYOUT_MODE,
                          tlpa_pkg::REG_W'($urandom_range(tlpa_pkg::MODE_TO_HWNC,
                                                          MODE_UNUSED_HI)));
                write_dims(tlpa_pkg::REG_W'($urandom_range(1, 3)),
                           tlpa_pkg::REG_W'($urandom_range(1, 3)),
                           tlpa_pkg::REG_W'($urandom_range(1, 3)),
                           tlpa_pkg::REG_W'($urandom_range(1, 3)));
                volume = int'(eff_count(batch_sh) * eff_count(chan_sh) *
                              eff_count(row_sh) * eff_count(col_sh));
                count  = volume * $urandom_range(1, 2);
                if ($urandom_range(0, 3) == 0)
                begin
                    count += $urandom_range(1, volume);
                end
                repeat (count) send_element($urandom);
            end
            else if (kind < 85)
            begin
                write_reg(tlpa_pkg::REG_LAYOUT_MODE,
                          tlpa_pkg::REG_W'($urandom_range(0, (1 << tlpa_pkg::REG_W) - 1)));
                write_dims(pick_edge_count(), pick_edge_count(),
                           pick_edge_count(), pick_edge_count());
                repeat ($urandom_range(1, 8)) send_element($urandom);
            end
            else
            begin
                if ($urandom_range(0, 5) == 0)
                begin
                    write_reg(tlpa_pkg::cfg_idx_t'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                              tlpa_pkg::REG_W'($urandom));
                end
                else
                begin
                    write_reg(tlpa_pkg::cfg_idx_t'($urandom_range(tlpa_pkg::REG_LAYOUT_MODE,
                                                                  tlpa_pkg::REG_COLUMN_COUNT)),
                              tlpa_pkg::REG_W'($urandom_range(0, 4)));
                end
                repeat ($urandom_range(1, 12)) send_element($urandom);
            end
        end
        quiet = 1'b0;
    endtask

    // drain, report and end the run
    task automatic finish_run();
        elem_ch.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            error_count++;
            $display("%0d expected results never arrived", pending_results.size());
        end
        $display("checked %0d elements over %0d register writes", results_checked, cfg_writes);
        $display("%0d tensors closed, %0d results flagged oversized, %0d errors",
                 tensors_closed, overflow_seen, error_count);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    endtask

    // main sequence
    initial
    begin
        elem_ch.valid        <= 1'b0;
        elem_ch.element_bits <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.reg_index     <= '0;
        cfg_ch.reg_data      <= '0;
        rst_n                <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_saturation_and_wrap();
        test_zero_and_shrunk_counts();
        test_each_layout();
        test_random_streams();
        finish_run();
    end

    // watchdog
    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

[tensor_layout_permute_address.f]
rtl/core/tlpa_pkg.sv
rtl/core/tlpa_if.sv
rtl/core/tensor_layout_permute_address.sv
dv/tensor_layout_permute_address_tb.sv
